### design/assert_macros.svh
// Assertion macros shared by the batched matrix-vector multiply design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bmvm_pkg.sv
// Types and constants of the batched matrix-vector multiply block.
package bmvm_pkg;

  localparam int VAL_W    = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int CFG_W    = 7;
  localparam int P_W      = 3;
  localparam int N_W      = 7;
  localparam int XB_W     = 5;
  localparam int YB_W     = 5;
  localparam int DRAIN_LAST = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_READ_C  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_DIM_P  = 2'd0,
    CFG_DIM_N  = 2'd1,
    CFG_DIM_XB = 2'd2,
    CFG_DIM_YB = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    func_t              func;
    logic [1:0]         row_h;
    logic [5:0]         inner_k;
    logic [3:0]         col_i;
    logic [3:0]         col_j;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic signed [39:0] c_value;
    logic               index_error;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } ctrl_status_t;

  function automatic logic [CFG_W-1:0] sat_size(logic [CFG_W-1:0] raw, int unsigned max);
    if (raw == '0) begin
      return CFG_W'(1);
    end
    if (int'(raw) > int'(max)) begin
      return CFG_W'(max);
    end
    return raw;
  endfunction

endpackage

### design/batched_matrix_vector_multiply.sv
// Batched matrix-vector multiply top level: operand memories, request decode and result register.
//
// Load and read requests are taken one per cycle unless a compute runs or a result is stalled;
// a read or a rejected load returns its result in the cycle after it is accepted, and a new
// request is taken while that result is being handed over. A compute request holds stall while
// the single multiply-accumulate unit takes one a/b pair per cycle and the drain state empties
// its read, product and accumulate stages into the c memory. There is no clearing pass after
// reset. Sizes are truncated to their field, then above maximum act as maximum, zero as one.
`include "assert_macros.svh"

module batched_matrix_vector_multiply import bmvm_pkg::*; #(
  parameter int P_MAX  = 4,
  parameter int N_MAX  = 64,
  parameter int XB_MAX = 16,
  parameter int YB_MAX = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  localparam int A_DEPTH = P_MAX * N_MAX * XB_MAX;
  localparam int B_DEPTH = N_MAX * YB_MAX;
  localparam int C_DEPTH = P_MAX * XB_MAX * YB_MAX;
  localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

  logic signed [VAL_W-1:0] a_mem [A_DEPTH];
  logic signed [VAL_W-1:0] b_mem [B_DEPTH];
  logic signed [ACC_W-1:0] c_mem [C_DEPTH];

  logic [P_W-1:0]  dim_p;
  logic [N_W-1:0]  dim_n;
  logic [XB_W-1:0] dim_xb;
  logic [YB_W-1:0] dim_yb;
  logic [P_W-1:0]  p_eff;
  logic [N_W-1:0]  n_eff;
  logic [XB_W-1:0] xb_eff;
  logic [YB_W-1:0] yb_eff;

  logic            accept;
  logic            a_ok, b_ok, c_ok, gives_rsp;
  logic [A_AW-1:0] ld_a_addr;
  logic [B_AW-1:0] ld_b_addr;
  logic [C_AW-1:0] rd_c_addr;

  mac_ctl_t                issue, issue_r;
  logic [A_AW-1:0]         a_addr;
  logic [B_AW-1:0]         b_addr;
  logic [C_AW-1:0]         c_addr, c_addr_r;
  logic signed [VAL_W-1:0] a_rd, b_rd;
  ctrl_status_t            status;
  logic                    mac_wr_en;
  logic [C_AW-1:0]         mac_wr_addr;
  logic signed [ACC_W-1:0] mac_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_p  <= P_W'(1);
      dim_n  <= N_W'(64);
      dim_xb <= XB_W'(16);
      dim_yb <= YB_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIM_P:  dim_p  <= cfg_data[P_W-1:0];
        CFG_DIM_N:  dim_n  <= cfg_data[N_W-1:0];
        CFG_DIM_XB: dim_xb <= cfg_data[XB_W-1:0];
        CFG_DIM_YB: dim_yb <= cfg_data[YB_W-1:0];
        default: ;
      endcase
    end
  end

  assign p_eff  = P_W'(sat_size(CFG_W'(dim_p), P_MAX));
  assign n_eff  = N_W'(sat_size(CFG_W'(dim_n), N_MAX));
  assign xb_eff = XB_W'(sat_size(CFG_W'(dim_xb), XB_MAX));
  assign yb_eff = YB_W'(sat_size(CFG_W'(dim_yb), YB_MAX));

  assign req_stall = status.busy || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign a_ok = ({1'b0, req.row_h} < p_eff) && ({1'b0, req.inner_k} < n_eff) &&
                ({1'b0, req.col_i} < xb_eff);
  assign b_ok = ({1'b0, req.inner_k} < n_eff) && ({1'b0, req.col_j} < yb_eff);
  assign c_ok = ({1'b0, req.row_h} < p_eff) && ({1'b0, req.col_i} < xb_eff) &&
                ({1'b0, req.col_j} < yb_eff);

  always_comb begin
    gives_rsp = 1'b0;
    unique case (req.func)
      FUNC_LOAD_A:  gives_rsp = !a_ok;
      FUNC_LOAD_B:  gives_rsp = !b_ok;
      FUNC_COMPUTE: gives_rsp = 1'b0;
      FUNC_READ_C:  gives_rsp = 1'b1;
      default:      gives_rsp = 1'b0;
    endcase
  end

  assign ld_a_addr = A_AW'((int'(req.row_h) * N_MAX + int'(req.inner_k)) * XB_MAX +
                           int'(req.col_i));
  assign ld_b_addr = B_AW'(int'(req.inner_k) * YB_MAX + int'(req.col_j));
  assign rd_c_addr = C_AW'((int'(req.row_h) * XB_MAX + int'(req.col_i)) * YB_MAX +
                           int'(req.col_j));

  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_LOAD_A && a_ok) begin
      a_mem[ld_a_addr] <= req.value;
    end
    a_rd <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_LOAD_B && b_ok) begin
      b_mem[ld_b_addr] <= req.value;
    end
    b_rd <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (mac_wr_en) begin
      c_mem[mac_wr_addr] <= mac_wr_data;
    end
    if (accept && gives_rsp) begin
      if (req.func == FUNC_READ_C && c_ok) begin
        rsp.c_value     <= c_mem[rd_c_addr];
        rsp.index_error <= 1'b0;
      end else begin
        rsp.c_value     <= '0;
        rsp.index_error <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && gives_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_r <= '0;
    end else begin
      issue_r <= issue;
    end
    c_addr_r <= c_addr;
  end

  bmvm_ctrl #(
    .N_MAX  (N_MAX),
    .XB_MAX (XB_MAX),
    .YB_MAX (YB_MAX),
    .A_AW   (A_AW),
    .B_AW   (B_AW),
    .C_AW   (C_AW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && req.func == FUNC_COMPUTE),
    .p_eff  (p_eff),
    .n_eff  (n_eff),
    .xb_eff (xb_eff),
    .yb_eff (yb_eff),
    .issue  (issue),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .c_addr (c_addr),
    .status (status)
  );

  bmvm_mac #(
    .C_AW (C_AW)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (issue_r),
    .caddr   (c_addr_r),
    .a       (a_rd),
    .b       (b_rd),
    .wr_en   (mac_wr_en),
    .wr_addr (mac_wr_addr),
    .wr_data (mac_wr_data)
  );

  `ASSERT_NEXT(a_compute_busy, clk, rst, accept && req.func == FUNC_COMPUTE, status.busy, "compute request did not start the sequencer")
  `ASSERT_ALWAYS(a_cwrite_busy, clk, rst, !mac_wr_en || status.busy, "c memory written outside a compute")
  `ASSERT_NEXT(a_read_rsp, clk, rst, accept && req.func == FUNC_READ_C, rsp_valid, "read request gave no result")
  `ASSERT_ALWAYS(a_issue_busy, clk, rst, !issue_r.valid || status.busy, "operand pair in flight while idle")

endmodule

### design/bmvm_mac.sv
// Shared multiply-accumulate unit: registered product, then 40-bit accumulator.
module bmvm_mac import bmvm_pkg::*; #(
  parameter int C_AW = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic [C_AW-1:0]         caddr,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic                    wr_en,
  output logic [C_AW-1:0]         wr_addr,
  output logic signed [ACC_W-1:0] wr_data
);

  mac_ctl_t                  ctl1;
  logic [C_AW-1:0]           caddr1;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1  <= '0;
      wr_en <= 1'b0;
    end else begin
      ctl1  <= ctl;
      wr_en <= ctl1.valid && ctl1.last;
    end
    prod   <= a * b;
    caddr1 <= caddr;
    if (ctl1.valid) begin
      acc     <= ctl1.first ? prod_ext : acc + prod_ext;
      wr_addr <= caddr1;
    end
  end

  assign wr_data = acc;

endmodule

### design/bmvm_ctrl.sv
// Compute sequencer: walks h, i, j and k and issues one operand pair per cycle while running.
module bmvm_ctrl import bmvm_pkg::*; #(
  parameter int N_MAX  = 64,
  parameter int XB_MAX = 16,
  parameter int YB_MAX = 16,
  parameter int A_AW   = 12,
  parameter int B_AW   = 10,
  parameter int C_AW   = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [P_W-1:0]   p_eff,
  input  logic [N_W-1:0]   n_eff,
  input  logic [XB_W-1:0]  xb_eff,
  input  logic [YB_W-1:0]  yb_eff,
  output mac_ctl_t         issue,
  output logic [A_AW-1:0]  a_addr,
  output logic [B_AW-1:0]  b_addr,
  output logic [C_AW-1:0]  c_addr,
  output ctrl_status_t     status
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [P_W-1:0]  h;
  logic [N_W-1:0]  k;
  logic [XB_W-1:0] i;
  logic [YB_W-1:0] j;
  logic [1:0]      drain;
  logic            k_last, j_last, i_last, h_last;

  assign k_last = (k == n_eff - N_W'(1));
  assign j_last = (j == yb_eff - YB_W'(1));
  assign i_last = (i == xb_eff - XB_W'(1));
  assign h_last = (h == p_eff - P_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (k_last && j_last && i_last && h_last) state_next = ST_DRAIN;
      ST_DRAIN: if (drain == 2'(DRAIN_LAST)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h     <= '0;
      k     <= '0;
      i     <= '0;
      j     <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        h     <= '0;
        k     <= '0;
        i     <= '0;
        j     <= '0;
        drain <= '0;
      end else if (state == ST_RUN) begin
        if (!k_last) begin
          k <= k + N_W'(1);
        end else begin
          k <= '0;
          if (!j_last) begin
            j <= j + YB_W'(1);
          end else begin
            j <= '0;
            if (!i_last) begin
              i <= i + XB_W'(1);
            end else begin
              i <= '0;
              h <= h + P_W'(1);
            end
          end
        end
      end else begin
        drain <= drain + 2'd1;
      end
    end
  end

  assign issue.valid = (state == ST_RUN);
  assign issue.first = (k == '0);
  assign issue.last  = k_last;

  assign a_addr = A_AW'((int'(h) * N_MAX + int'(k)) * XB_MAX + int'(i));
  assign b_addr = B_AW'(int'(k) * YB_MAX + int'(j));
  assign c_addr = C_AW'((int'(h) * XB_MAX + int'(i)) * YB_MAX + int'(j));

  assign status.busy = (state != ST_IDLE);

endmodule
